// ===== hdl/limit_order_book_matcher_core_assert.svh =====
// Assertion macros for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH
`ifndef SYNTH
`define LOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes of the order book matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lobm_pkg;
    localparam int PRICE_W = 16;
    localparam int QTY_W   = 24;
    localparam int NUM_W   = 32;

    typedef enum logic [1:0] {
        OP_LIMIT  = 2'd0,
        OP_MARKET = 2'd1,
        OP_CANCEL = 2'd2,
        OP_MODIFY = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        K_TRADE     = 4'd0,
        K_RESTED    = 4'd1,
        K_FILLED    = 4'd2,
        K_MKT_PART  = 4'd3,
        K_MKT_CANCL = 4'd4,
        K_CANCELLED = 4'd5,
        K_NOT_FOUND = 4'd6,
        K_UNCHANGED = 4'd7,
        K_REJECTED  = 4'd8,
        K_BOOK_FULL = 4'd9,
        K_MODIFIED  = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FILL,
        S_EMIT,
        S_WAIT
    } t_state;

    // one resting order as carried along the chain
    typedef struct packed {
        logic               valid;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   remaining;
        logic [NUM_W-1:0]   number;
        logic [NUM_W-1:0]   arrival;
    } t_entry;

    // query broadcast to all cells
    typedef struct packed {
        logic               side;
        logic               market;
        logic [PRICE_W-1:0] limit;
        logic [NUM_W-1:0]   target;
        logic [NUM_W-1:0]   now;
    } t_query;

    // command from the controller to the cells
    typedef struct packed {
        logic               scan;
        logic               wr;
        logic               clr;
        logic               sub;
        logic [QTY_W-1:0]   amount;
        t_entry             data;
    } t_cmd;

    // running best candidate handed from cell to cell
    typedef struct packed {
        logic               found;
        logic               free_found;
        logic               tgt_found;
        logic [5:0]         best_idx;
        logic [5:0]         free_idx;
        logic [5:0]         tgt_idx;
        t_entry             best;
        t_entry             tgt;
        logic [NUM_W-1:0]   best_age;
    } t_cand;
endpackage

// ===== hdl/lobm_cell.sv =====
// ----------------------------------------------------------------------------
// lobm_cell
// One order slot: holds an order and folds itself into the candidate chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lobm_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [5:0]      i_sel,
    input  lobm_pkg::t_cmd   i_cmd,
    input  lobm_pkg::t_query i_query,
    input  lobm_pkg::t_cand  i_cand,
    output lobm_pkg::t_cand  o_cand
);
    import lobm_pkg::*;

    t_entry r_ent;
    t_cand  r_cand;
    t_cand  n_cand;
    logic   hit;
    logic   price_ok;
    logic   better;
    logic [NUM_W-1:0] age;
    logic   me;

    assign me  = (i_sel == 6'(IDX));
    assign age = i_query.now - r_ent.arrival;

    // eligibility and priority against the running best
    always_comb begin
        price_ok = i_query.market ||
                   (i_query.side == 1'b0 ? r_ent.price <= i_query.limit
                                         : r_ent.price >= i_query.limit);
        hit = r_ent.valid && (r_ent.side != i_query.side) && price_ok;
        if (!i_cand.found) begin
            better = 1'b1;
        end else if (r_ent.price != i_cand.best.price) begin
            better = i_query.side == 1'b0 ? r_ent.price < i_cand.best.price
                                          : r_ent.price > i_cand.best.price;
        end else begin
            better = age > i_cand.best_age;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (me && i_cmd.wr) begin
            r_ent <= i_cmd.data;
        end else if (me && i_cmd.clr) begin
            r_ent.valid <= 1'b0;
        end else if (me && i_cmd.sub) begin
            r_ent.remaining <= r_ent.remaining - i_cmd.amount;
            if (r_ent.remaining == i_cmd.amount) begin
                r_ent.valid <= 1'b0;
            end
        end
    end

    // candidate update: best order, first free slot, first target match
    always_comb begin
        n_cand = i_cand;
        if (hit && better) begin
            n_cand.found    = 1'b1;
            n_cand.best     = r_ent;
            n_cand.best_idx = 6'(IDX);
            n_cand.best_age = age;
        end
        if (!r_ent.valid && !i_cand.free_found) begin
            n_cand.free_found = 1'b1;
            n_cand.free_idx   = 6'(IDX);
        end
        if (r_ent.valid && r_ent.side == i_query.side &&
            r_ent.number == i_query.target && !i_cand.tgt_found) begin
            n_cand.tgt_found = 1'b1;
            n_cand.tgt_idx   = 6'(IDX);
            n_cand.tgt       = r_ent;
        end
    end

    // candidate stage, registered toward the neighbor
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end
    assign o_cand = r_cand;
endmodule

// ===== hdl/lobm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer: runs chain scans, fills, placement and result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "limit_order_book_matcher_core_assert.svh"
module lobm_ctrl #(
    parameter int SLOTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [79:0]      s_axis_tdata,
    input  logic [1:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [159:0]     m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [4:0]       m_axis_tuser,
    output logic [5:0]       o_sel,
    output lobm_pkg::t_cmd   o_cmd,
    output lobm_pkg::t_query o_query,
    input  lobm_pkg::t_cand  i_cand
);
    import lobm_pkg::*;

    localparam int CW = $clog2(SLOTS + 2);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_op    r_op;
    logic   r_side;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0] r_qty, r_rem;
    logic [NUM_W-1:0] r_target, r_own;
    logic [NUM_W-1:0] r_nbuy, r_nsell, r_ntrade, r_narr;
    logic   r_sweep, r_done;
    logic   r_ovalid;
    logic [159:0] r_odata;
    logic   r_olast;
    logic [4:0] r_ouser;
    t_cand  r_cand;
    logic [QTY_W-1:0] fill_q;
    logic   in_submit;
    logic   in_reject;

    // one result staged for output
    logic   emit;
    t_kind  e_kind;
    logic [NUM_W-1:0] e_own, e_ctr, e_trd;
    logic [PRICE_W-1:0] e_price;
    logic [QTY_W-1:0] e_exq, e_left;
    logic   e_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

    assign o_query.side   = r_side;
    assign o_query.market = (r_op == OP_MARKET);
    assign o_query.limit  = r_price;
    assign o_query.target = r_target;
    assign o_query.now    = r_narr;

    assign fill_q = (r_cand.best.remaining < r_rem) ? r_cand.best.remaining : r_rem;

    // incoming request classification
    assign in_submit = (s_axis_tuser == OP_LIMIT) || (s_axis_tuser == OP_MARKET);
    assign in_reject = in_submit && (s_axis_tdata[40:17] == '0 ||
                       (s_axis_tuser == OP_LIMIT && s_axis_tdata[16:1] == '0));

    // next state, commands and results
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_sel   = '0;
        o_cmd   = '0;
        emit    = 1'b0;
        e_kind  = K_REJECTED;
        e_own   = r_own;
        e_ctr   = '0;
        e_trd   = '0;
        e_price = r_price;
        e_exq   = '0;
        e_left  = '0;
        e_last  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(SLOTS)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_WAIT;
                if (r_sweep) begin
                    if (r_rem != '0 && r_cand.found) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else if (r_op == OP_LIMIT || r_op == OP_MARKET) begin
                    emit = 1'b1;
                end else if (!r_cand.tgt_found) begin
                    emit = 1'b1;
                    e_kind = K_NOT_FOUND; e_price = '0;
                end else if (r_op == OP_CANCEL) begin
                    emit = 1'b1;
                    e_kind = K_CANCELLED; e_price = r_cand.tgt.price;
                    e_left = r_cand.tgt.remaining;
                    o_sel = r_cand.tgt_idx; o_cmd.clr = 1'b1;
                end else if (r_price == r_cand.tgt.price &&
                             r_qty == r_cand.tgt.remaining) begin
                    emit = 1'b1;
                    e_kind = K_UNCHANGED; e_left = r_qty;
                end else if (r_price == '0 || r_qty == '0) begin
                    emit = 1'b1;
                    e_price = r_cand.tgt.price; e_left = r_cand.tgt.remaining;
                end else if (r_price != r_cand.tgt.price) begin
                    o_sel = r_cand.tgt_idx; o_cmd.clr = 1'b1;
                    n_state = S_SCAN; n_cnt = '0;
                end else begin
                    emit = 1'b1;
                    e_kind = K_MODIFIED; e_left = r_qty;
                    o_sel = r_cand.tgt_idx; o_cmd.wr = 1'b1;
                    o_cmd.data = '{valid: 1'b1, side: r_side, price: r_price,
                        remaining: r_qty, number: r_target, arrival: r_narr};
                end
            end
            S_FILL: begin
                if (!r_ovalid || m_axis_tready) begin
                    emit = 1'b1;
                    e_kind = K_TRADE; e_ctr = r_cand.best.number; e_trd = r_ntrade;
                    e_price = r_cand.best.price; e_exq = fill_q;
                    e_left = r_rem - fill_q; e_last = 1'b0;
                    o_sel = r_cand.best_idx; o_cmd.sub = 1'b1; o_cmd.amount = fill_q;
                    n_state = S_SCAN; n_cnt = '0;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    emit = 1'b1;
                    n_state = S_WAIT;
                    e_left = r_rem;
                    if (r_op == OP_MARKET) begin
                        e_price = '0;
                        e_kind = (r_rem == '0) ? K_FILLED :
                                 (r_rem < r_qty) ? K_MKT_PART : K_MKT_CANCL;
                    end else if (r_op == OP_MODIFY) begin
                        e_kind = K_MODIFIED;
                        if (r_rem != '0) begin
                            o_sel = r_cand.tgt_idx; o_cmd.wr = 1'b1;
                        end
                    end else if (r_rem == '0) begin
                        e_kind = K_FILLED;
                    end else if (r_cand.free_found) begin
                        e_kind = K_RESTED;
                        o_sel = r_cand.free_idx; o_cmd.wr = 1'b1;
                    end else begin
                        e_kind = K_BOOK_FULL;
                    end
                    o_cmd.data = '{valid: 1'b1, side: r_side, price: r_price,
                        remaining: r_rem, number: r_own, arrival: r_narr};
                end
            end
            S_WAIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // decide-state results need the output register free
        if (r_state == S_DECIDE && emit && r_ovalid && !m_axis_tready) begin
            emit = 1'b0; n_state = S_DECIDE; o_cmd = '0; n_cnt = r_cnt;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_nbuy   <= 32'd1;
            r_nsell  <= 32'd1;
            r_ntrade <= 32'd1;
            r_narr   <= '0;
            r_ovalid <= 1'b0;
            r_sweep  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_ovalid <= 1'b1;
                r_odata  <= {e_left, e_exq, e_price, e_trd, e_ctr, e_own};
                r_ouser  <= {r_side, e_kind};
                r_olast  <= e_last;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (o_cmd.wr) r_narr <= r_narr + 1'b1;
            if (o_cmd.sub) begin
                r_ntrade <= r_ntrade + 1'b1;
                r_rem    <= r_rem - fill_q;
            end
            if (r_state == S_IDLE && s_axis_tvalid) begin
                r_op     <= t_op'(s_axis_tuser);
                r_side   <= s_axis_tdata[0];
                r_price  <= s_axis_tdata[16:1];
                r_qty    <= s_axis_tdata[40:17];
                r_rem    <= in_reject ? '0 : s_axis_tdata[40:17];
                r_target <= s_axis_tdata[72:41];
                r_sweep  <= in_submit && !in_reject;
                // submits: reject or take a number and sweep; other ops use the target number
                if (!in_submit) begin
                    r_own <= s_axis_tdata[72:41];
                end else if (in_reject) begin
                    r_own <= '0;
                end else if (s_axis_tdata[0]) begin
                    r_own <= r_nsell; r_nsell <= r_nsell + 1'b1;
                end else begin
                    r_own <= r_nbuy; r_nbuy <= r_nbuy + 1'b1;
                end
            end else if (r_state == S_DECIDE && n_state == S_SCAN) begin
                r_sweep <= 1'b1;
            end
            r_done <= emit && e_last;
        end
    end

    // chain output captured as the scan completes
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_cnt == CW'(SLOTS)) begin
            r_cand.found <= i_cand.found;
            r_cand.best <= i_cand.best;
            r_cand.best_idx <= i_cand.best_idx;
            r_cand.free_found <= i_cand.free_found;
            r_cand.free_idx <= i_cand.free_idx;
            if (!r_sweep) begin
                r_cand.tgt_found <= i_cand.tgt_found;
                r_cand.tgt_idx <= i_cand.tgt_idx;
                r_cand.tgt <= i_cand.tgt;
            end
        end
    end

    `LOB_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == S_IDLE)
    `LOB_ASSERT_NEXT(a_fill_trade, i_clk, i_rst_n, o_cmd.sub, r_ovalid && !r_olast)
    `LOB_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.wr, o_cmd.clr, o_cmd.sub}))
    `LOB_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, emit && e_last, r_done)
endmodule

// ===== hdl/limit_order_book_matcher_core.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority limit order book built from a chain of order slots.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tuser = op; tdata = side, price, quantity,
// order_number). Results leave on m_axis (tuser = kind, order_side;
// tdata = own, counter, trade numbers, exec price/quantity, left quantity),
// tlast marks the final result of a request.
// One request is handled at a time. Every lookup or best-order search is a
// pass through the slot chain. A cancel, reject or not-found result is
// staged in the decide state that ends the pass, and the next request is
// taken after the wait state; a submit status is staged one state later,
// in the emit state. Each trade adds a fill and another pass, and a price
// modify one more pass.
// The result register holds a result while m_axis stalls; the sequencer
// waits for it to drain before staging the next result.
// Reset empties all slots and restarts the buy, sell and trade numbers at
// one and the arrival counter at zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module limit_order_book_matcher_core #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // side, price, quantity, order_number
    input  logic [1:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // own_number, counter_number, trade_number, exec_price, exec_quantity,
    // left_quantity
    output logic [159:0] m_axis_tdata,
    output logic         m_axis_tlast,
    output logic [4:0]   m_axis_tuser   // kind, order_side
);
    import lobm_pkg::*;

    logic [5:0] sel;
    t_cmd   cmd;
    t_query query;
    t_cand  chain [ORDER_SLOTS+1];

    assign chain[0] = '0;

    lobm_ctrl #(.SLOTS(ORDER_SLOTS)) u_ctrl (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .m_axis_tuser,
        .o_sel(sel), .o_cmd(cmd), .o_query(query), .i_cand(chain[ORDER_SLOTS])
    );

    // slot chain
    for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
        lobm_cell #(.IDX(g)) u_cell (
            .i_clk, .i_rst_n,
            .i_sel(sel), .i_cmd(cmd), .i_query(query),
            .i_cand(chain[g]), .o_cand(chain[g+1])
        );
    end
endmodule
